// File: sv/wpc_pkg.sv
// Shared constants, codes and control types for the windowed pixel cursor.
// Used by the controller, datapath, divider and top level; depends on nothing.
`default_nettype none

package wpc_pkg;

  // Frame buffer geometry
  localparam int unsigned SCREEN_WIDTH = 240;
  // Width that holds the screen width and the largest window height
  localparam int GEOM_W = 13;
  // Linear pixel index: row * screen width + column
  localparam int PIX_W = 9 + GEOM_W + 1;

  // Shared divider: 17-bit dividend, divisor up to 512
  localparam int DIV_DVD_W = 17;
  localparam int DIV_DSR_W = 10;
  localparam int DIV_STEPS = DIV_DVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Stream and configuration widths
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 96;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Command carried in s_tuser
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SKIP  = 1'b1
  } cmd_kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_BASE = 3'd0,
    REG_WIN_LEFT   = 3'd1,
    REG_WIN_RIGHT  = 3'd2,
    REG_WIN_TOP    = 3'd3,
    REG_WIN_BOTTOM = 3'd4
  } reg_index_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_Q,
    ST_DIV_R,
    ST_COMMIT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic div_start_q;
    logic div_start_r;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip_long;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: sv/wpc_divider.sv
// Restoring divider, one quotient bit per cycle, shared by both skip divisions.
// Depends on wpc_pkg for its widths.
`default_nettype none

module wpc_divider (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [wpc_pkg::DIV_DVD_W-1:0]  dividend,
  input  wire logic [wpc_pkg::DIV_DSR_W-1:0]  divisor,
  output logic                                busy,
  output logic [wpc_pkg::DIV_DVD_W-1:0]       quotient,
  output logic [wpc_pkg::DIV_DSR_W-1:0]       remainder
);
  import wpc_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DSR_W-1:0] dsr;
  logic [DIV_DSR_W:0]   trial;
  logic                 fits;

  // Bring down the next dividend bit and try a subtraction
  assign trial = {remainder, quotient[DIV_DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  // Control: run a fixed number of steps after start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      dsr       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient <= {quotient[DIV_DVD_W-2:0], fits};
      if (fits) begin
        remainder <= DIV_DSR_W'(trial - {1'b0, dsr});
      end else begin
        remainder <= trial[DIV_DSR_W-1:0];
      end
    end
  end

  // A new division never starts over one still in progress
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider not busy after start");

endmodule

`default_nettype wire

// File: sv/wpc_ctrl.sv
// Controller state machine: sequences accept, execute, divisions and commit.
// Depends on wpc_pkg for state, command and status types.
`default_nettype none

module wpc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire wpc_pkg::dp_status_t status,
  output wpc_pkg::ctrl_cmd_t       cmd
);
  import wpc_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.skip_long) begin
          cmd.div_start_q = 1'b1;
          state_next      = ST_DIV_Q;
        end else if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV_Q: begin
        if (!status.div_busy) begin
          cmd.div_start_r = 1'b1;
          state_next      = ST_DIV_R;
        end
      end
      ST_DIV_R: begin
        if (!status.div_busy) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/wpc_datapath.sv
// Datapath: window registers, cursor, address arithmetic and output register.
// Depends on wpc_pkg and instantiates wpc_divider for skip division and modulo.
`default_nettype none

module wpc_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire wpc_pkg::ctrl_cmd_t              cmd,
  output wpc_pkg::dp_status_t                  status,
  input  wire logic [wpc_pkg::IN_DATA_W-1:0]   s_tdata,
  input  wire logic                            s_tuser,
  input  wire logic                            cfg_valid,
  input  wire logic [wpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [wpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [wpc_pkg::OUT_DATA_W-1:0]       m_tdata,
  output logic                                 m_tuser
);
  import wpc_pkg::*;

  // Configuration registers
  logic [31:0] frame_base;
  logic [7:0]  win_left;
  logic [7:0]  win_right;
  logic [8:0]  win_top;
  logic [8:0]  win_bottom;

  // Cursor
  logic [7:0] cur_col;
  logic [8:0] cur_row;

  // Held input beat
  cmd_kind_t   in_cmd;
  logic [15:0] in_color;
  logic [15:0] in_count;

  // Column remainder of the first division
  logic [7:0] col_rem;

  // Window geometry
  logic [7:0]        eff_right;
  logic [8:0]        eff_bottom;
  logic [8:0]        win_w;
  logic [9:0]        win_h;
  logic [GEOM_W-1:0] scr_w;
  logic [GEOM_W-1:0] w_ext;
  logic [7:0]        row_skip;

  // Step arithmetic
  logic [8:0]  col_inc;
  logic [9:0]  row_inc;
  logic [7:0]  col_off;
  logic [8:0]  cols_left;
  logic        skip_long;
  logic [15:0] rest;
  logic [16:0] row_sum;
  logic [7:0]  col_next;
  logic [8:0]  row_next;

  // Address
  logic [PIX_W-1:0] pix_idx;
  logic [31:0]      pix_addr;

  // Divider
  logic                 div_start;
  logic [DIV_DVD_W-1:0] div_dividend;
  logic [DIV_DSR_W-1:0] div_divisor;
  logic                 div_busy;
  logic [DIV_DVD_W-1:0] div_quo;
  logic [DIV_DSR_W-1:0] div_rem;

  logic cfg_home;

  // Window geometry, inverted edges collapse to one column or row
  assign eff_right  = (win_right < win_left) ? win_left : win_right;
  assign eff_bottom = (win_bottom < win_top) ? win_top : win_bottom;
  assign win_w      = {1'b0, eff_right} - {1'b0, win_left} + 9'd1;
  assign win_h      = {1'b0, eff_bottom} - {1'b0, win_top} + 10'd1;
  assign scr_w      = GEOM_W'(SCREEN_WIDTH);
  assign w_ext      = GEOM_W'(win_w);
  assign row_skip   = (scr_w > w_ext) ? 8'(scr_w - w_ext) : 8'd0;

  // Address of the cursor pixel, two bytes per pixel
  assign pix_idx  = PIX_W'(cur_row) * PIX_W'(SCREEN_WIDTH) + PIX_W'(cur_col);
  assign pix_addr = frame_base + 32'({pix_idx, 1'b0});

  // Single-pixel advance with row and frame wrap
  assign col_inc = {1'b0, cur_col} + 9'd1;
  assign row_inc = {1'b0, cur_row} + 10'd1;

  // Skip: distance to the end of the current line
  assign col_off   = cur_col - win_left;
  assign cols_left = win_w - {1'b0, col_off};
  assign skip_long = (in_cmd == CMD_SKIP) && (in_count >= 16'(cols_left));
  assign rest      = in_count - 16'(cols_left);
  assign row_sum   = 17'(cur_row - win_top) + 17'd1 + div_quo;

  // Select the cursor after the step
  always_comb begin
    priority if (in_cmd == CMD_WRITE) begin
      if (col_inc > {1'b0, eff_right}) begin
        col_next = win_left;
        row_next = (row_inc > {1'b0, eff_bottom}) ? win_top : row_inc[8:0];
      end else begin
        col_next = col_inc[7:0];
        row_next = cur_row;
      end
    end else if (!skip_long) begin
      col_next = cur_col + in_count[7:0];
      row_next = cur_row;
    end else begin
      col_next = win_left + col_rem;
      row_next = win_top + div_rem[8:0];
    end
  end

  // Divider operands: rest by width, then row sum by height
  assign div_start    = cmd.div_start_q | cmd.div_start_r;
  assign div_dividend = cmd.div_start_r ? row_sum : DIV_DVD_W'(rest);
  assign div_divisor  = cmd.div_start_r ? win_h : DIV_DSR_W'(win_w);

  wpc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Status to the controller
  assign status.skip_long = skip_long;
  assign status.div_busy  = div_busy;
  assign status.out_free  = !m_tvalid || m_tready;

  // Hold the accepted input beat
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_cmd   <= cmd_kind_t'(s_tuser);
      in_color <= s_tdata[15:0];
      in_count <= s_tdata[31:16];
    end
  end

  // Keep the column remainder while the divider works on the row
  always_ff @(posedge clk) begin
    if (cmd.div_start_r) begin
      col_rem <= div_rem[7:0];
    end
  end

  // Configuration writes; window writes home the cursor
  always_comb begin
    cfg_home = 1'b0;
    if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_WIN_LEFT, REG_WIN_RIGHT, REG_WIN_TOP, REG_WIN_BOTTOM: cfg_home = 1'b1;
        default: cfg_home = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base <= '0;
      win_left   <= 8'd0;
      win_right  <= 8'd239;
      win_top    <= 9'd0;
      win_bottom <= 9'd319;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_FRAME_BASE: frame_base <= cfg_data;
        REG_WIN_LEFT:   win_left   <= cfg_data[7:0];
        REG_WIN_RIGHT:  win_right  <= cfg_data[7:0];
        REG_WIN_TOP:    win_top    <= cfg_data[8:0];
        REG_WIN_BOTTOM: win_bottom <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Cursor: advance on commit, home on window write
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= 8'd0;
      cur_row <= 9'd0;
    end else if (cmd.commit) begin
      cur_col <= col_next;
      cur_row <= row_next;
    end else if (cfg_home) begin
      cur_col <= (cfg_index == REG_WIN_LEFT) ? cfg_data[7:0] : win_left;
      cur_row <= (cfg_index == REG_WIN_TOP) ? cfg_data[8:0] : win_top;
    end
  end

  // Output register: hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tuser <= (in_cmd == CMD_WRITE);
      m_tdata <= {6'd0, row_skip, win_h[8:0], win_w[7:0], row_next, col_next,
                  (in_cmd == CMD_WRITE) ? in_color : 16'd0, pix_addr};
    end
  end

  // Cursor stays inside the effective window
  a_col_in_window: assert property (@(posedge clk) disable iff (rst)
      (cur_col >= win_left) && (cur_col <= eff_right))
    else $error("cursor column outside window");

  a_row_in_window: assert property (@(posedge clk) disable iff (rst)
      (cur_row >= win_top) && (cur_row <= eff_bottom))
    else $error("cursor row outside window");

  // A result never overwrites a beat that has not been taken
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
      cmd.commit |-> (!m_tvalid || m_tready))
    else $error("result committed over a waiting beat");

endmodule

`default_nettype wire

// File: sv/windowed_pixel_cursor.sv
// Windowed pixel cursor: frame-buffer address generator for a drawing window.
// A pixel write beat is loaded when accepted and committed from the execute state
// into the output register; a skip that stays on the current line takes the same
// path. A skip that crosses a line runs two passes of the shared 17-step restoring
// divider (offset by width, then rows by height) before its commit. No new input
// beat is taken until the last one has committed. The next input beat is taken while
// a result beat waits; its own result then holds until the output register is free.
// Window register writes move the cursor to the window's top-left corner.
// Depends on wpc_pkg, wpc_ctrl, wpc_datapath and wpc_divider.
`default_nettype none

module windowed_pixel_cursor (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [wpc_pkg::IN_DATA_W-1:0]   s_tdata,   // color[15:0], skip_count[31:16]
  input  wire logic                            s_tuser,   // command
  // Result stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // pixel_address[31:0], pixel_color[47:32], next_column[55:48], next_row[64:56],
  // window_width[72:65], window_height[81:73], row_skip[89:82], zero[95:90]
  output logic [wpc_pkg::OUT_DATA_W-1:0]       m_tdata,
  output logic                                 m_tuser,   // write_strobe
  // Configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [wpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [wpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wpc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Register writes are taken in any cycle
  assign cfg_ready = 1'b1;

  wpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  wpc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

// File: test/tb_windowed_pixel_cursor.sv
// Self-checking testbench for windowed_pixel_cursor: drives command beats and window
// register writes, predicts every result beat and compares them field by field.
// Depends on wpc_pkg and the windowed_pixel_cursor RTL.
`default_nettype none

module tb_windowed_pixel_cursor;
  timeunit 1ns;
  timeprecision 1ps;
  import wpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    cmd_kind_t   cmd;
    logic [15:0] color;
    logic [15:0] count;
  } pixel_cmd_t;

  typedef struct packed {
    logic        strobe;
    logic [31:0] addr;
    logic [15:0] color;
    logic [7:0]  col;
    logic [8:0]  row;
    logic [7:0]  width;
    logic [8:0]  height;
    logic [7:0]  row_skip;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;   // color[15:0], skip_count[31:16]
  logic s_tuser = 1'b0;                 // command
  logic m_tvalid;
  logic m_tready = 1'b0;
  // pixel_address[31:0], pixel_color[47:32], next_column[55:48], next_row[64:56],
  // window_width[72:65], window_height[81:73], row_skip[89:82], zero[95:90]
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;                        // write_strobe
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted register file and cursor
  int unsigned frame_base_r, win_left_r, win_right_r, win_top_r, win_bottom_r;
  int unsigned cursor_col, cursor_row;

  pixel_cmd_t    pixel_cmds[$];
  pixel_result_t expected_pixels[$];
  bit            in_fire = 1'b0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   cycle_count = 0;
  int unsigned   fail_count = 0;

  windowed_pixel_cursor dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Width of the window in columns, right edge clamped to the left edge
  function automatic int unsigned full_width();
    return ((win_right_r < win_left_r) ? win_left_r : win_right_r) - win_left_r + 1;
  endfunction

  // Work out the result beat of one command and move the predicted cursor
  function automatic pixel_result_t step_cursor(cmd_kind_t cmd, logic [15:0] color,
                                                logic [15:0] count);
    int unsigned right_edge, bottom_edge, w, h, next_col, next_row, line_left, rest;
    pixel_result_t r;
    right_edge  = (win_right_r < win_left_r) ? win_left_r : win_right_r;
    bottom_edge = (win_bottom_r < win_top_r) ? win_top_r : win_bottom_r;
    w = right_edge - win_left_r + 1;
    h = bottom_edge - win_top_r + 1;
    r.strobe = (cmd == CMD_WRITE);
    r.addr   = frame_base_r + 2 * (cursor_row * SCREEN_WIDTH + cursor_col);
    r.color  = (cmd == CMD_WRITE) ? color : 16'h0000;
    next_col = cursor_col;
    next_row = cursor_row;
    if (cmd == CMD_WRITE) begin
      // Advance one pixel, wrap to the next row, then back to the top row
      next_col = cursor_col + 1;
      if (next_col > right_edge) begin
        next_col = win_left_r;
        next_row = cursor_row + 1;
        if (next_row > bottom_edge) next_row = win_top_r;
      end
    end else begin
      line_left = w - (cursor_col - win_left_r);
      if (count < line_left) begin
        next_col = cursor_col + count;
      end else begin
        rest = count - line_left;
        next_row = win_top_r + (cursor_row - win_top_r + 1 + rest / w) % h;
        next_col = win_left_r + rest % w;
      end
    end
    cursor_col = next_col & 32'hFF;
    cursor_row = next_row & 32'h1FF;
    r.col      = 8'(cursor_col);
    r.row      = 9'(cursor_row);
    r.width    = 8'(w);
    r.height   = 9'(h);
    r.row_skip = 8'((SCREEN_WIDTH > w) ? SCREEN_WIDTH - w : 0);
    return r;
  endfunction

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    end
  endtask

  // Write one register over the configuration channel and mirror it
  task automatic write_reg(reg_index_t idx, int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FRAME_BASE: frame_base_r = value;
      REG_WIN_LEFT:   win_left_r   = value & 32'hFF;
      REG_WIN_RIGHT:  win_right_r  = value & 32'hFF;
      REG_WIN_TOP:    win_top_r    = value & 32'h1FF;
      REG_WIN_BOTTOM: win_bottom_r = value & 32'h1FF;
      default: ;
    endcase
    if (idx != REG_FRAME_BASE) begin
      cursor_col = win_left_r;
      cursor_row = win_top_r;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pick a window for the phase; the first few phases hit the corner cases
  task automatic configure_window(int phase);
    int unsigned base, left, right, top, bottom;
    bit all_regs;
    all_regs = 1'b1;
    base = $urandom();
    case (phase)
      1: begin  // one pixel far outside the screen, addresses wrap
        base = 32'hFFFF_FFF0; left = 255; right = 255; top = 511; bottom = 511;
      end
      2: begin  // widest and tallest window, masked geometry fields
        left = 0; right = 255; top = 0; bottom = 511;
      end
      3: begin  // inverted edges collapse to one column and one row
        left = 200; right = 10; top = 300; bottom = 5;
      end
      4: begin
        base = 0; left = 0; right = 0; top = 0; bottom = 0;
      end
      default: begin
        all_regs = ($urandom_range(3) != 0);
        case ($urandom_range(3))
          0: begin  // small window so rows and the whole window wrap often
            left = $urandom_range(0, 239); right = (left + $urandom_range(0, 7)) & 32'hFF;
            top = $urandom_range(0, 319); bottom = (top + $urandom_range(0, 7)) & 32'h1FF;
          end
          1: begin
            left = $urandom_range(0, 239); right = $urandom_range(0, 239);
            top = $urandom_range(0, 319); bottom = $urandom_range(0, 319);
          end
          2: begin
            left = $urandom_range(0, 255); right = $urandom_range(0, 255);
            top = $urandom_range(0, 511); bottom = $urandom_range(0, 511);
          end
          default: begin
            left = $urandom_range(0, 3); right = $urandom_range(236, 239);
            top = $urandom_range(0, 3); bottom = $urandom_range(316, 319);
          end
        endcase
      end
    endcase
    // Upper data bits beyond each register's width carry noise
    write_reg(REG_FRAME_BASE, base);
    if (all_regs || $urandom_range(1))
      write_reg(REG_WIN_LEFT, ($urandom() & 32'hFFFF_FF00) | left);
    if (all_regs || $urandom_range(1))
      write_reg(REG_WIN_RIGHT, ($urandom() & 32'hFFFF_FF00) | right);
    if (all_regs || $urandom_range(1))
      write_reg(REG_WIN_TOP, ($urandom() & 32'hFFFF_FE00) | top);
    if (all_regs || $urandom_range(1))
      write_reg(REG_WIN_BOTTOM, ($urandom() & 32'hFFFF_FE00) | bottom);
  endtask

  task automatic queue_cmd(cmd_kind_t cmd, logic [15:0] color, logic [15:0] count);
    pixel_cmd_t c;
    c.cmd = cmd;
    c.color = color;
    c.count = count;
    pixel_cmds.push_back(c);
  endtask

  // Mostly writes; skips land within a line, on a line boundary or far away
  task automatic queue_random(int n);
    int unsigned w;
    logic [15:0] count;
    w = full_width();
    for (int i = 0; i < n; i++) begin
      count = 16'($urandom());
      if ($urandom_range(99) < 65) begin
        queue_cmd(CMD_WRITE, 16'($urandom()), count);
      end else begin
        case ($urandom_range(3))
          0: count = 16'($urandom_range(0, 2 * w + 1));
          1: count = 16'(w * $urandom_range(0, 4) + $urandom_range(0, 1));
          2: count = 16'($urandom_range(0, 3));
          default: ;
        endcase
        queue_cmd(CMD_SKIP, 16'($urandom()), count);
      end
    end
  endtask

  // Hold until every beat is sent and every result has come back
  task automatic wait_drained();
    while (pixel_cmds.size() != 0 || s_tvalid || expected_pixels.size() != 0)
      @(posedge clk);
  endtask

  // Stimulus: reset, then phases of window settings and command beats
  initial begin : stimulus
    frame_base_r = 0;
    win_left_r   = 0;
    win_right_r  = 239;
    win_top_r    = 0;
    win_bottom_r = 319;
    cursor_col   = 0;
    cursor_row   = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 4) begin
        send_idle_pct = 37; recv_idle_pct = 50;
      end else if (phase < 8) begin
        send_idle_pct = 50; recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (phase == 0) begin
        // Full-screen window from reset: colour extremes, then skips of every reach
        queue_cmd(CMD_WRITE, 16'h0000, 16'hFFFF);
        queue_cmd(CMD_WRITE, 16'hFFFF, 16'h0000);
        queue_cmd(CMD_WRITE, 16'hF800, 16'h5A5A);
        queue_cmd(CMD_WRITE, 16'h07E0, 16'hA5A5);
        queue_cmd(CMD_SKIP, 16'hFFFF, 16'd0);
        queue_cmd(CMD_SKIP, 16'h0000, 16'd1);
        queue_cmd(CMD_SKIP, 16'h1234, 16'd229);
        queue_cmd(CMD_SKIP, 16'h0000, 16'd4);
        queue_cmd(CMD_SKIP, 16'h0000, 16'd240);
        queue_cmd(CMD_SKIP, 16'h0000, 16'd65535);
        queue_cmd(CMD_SKIP, 16'h0000, 16'd65534);
        queue_cmd(CMD_SKIP, 16'h0000, 16'd1000);
        queue_cmd(CMD_WRITE, 16'h001F, 16'd0);
        queue_cmd(CMD_WRITE, 16'h8000, 16'd0);
        queue_cmd(CMD_WRITE, 16'h0001, 16'd0);
        queue_random(ITEMS_PER_PHASE - 15);
      end else begin
        configure_window(phase);
        @(posedge clk);
        queue_random(ITEMS_PER_PHASE);
      end
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("windowed_pixel_cursor verification clean");
    end else begin
      $display("windowed_pixel_cursor verification failed");
    end
    $finish;
  end

  // Driver: present the next command beat, idle and stall at random
  always @(negedge clk) begin : driver
    pixel_cmd_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || in_fire) begin
        if (pixel_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          c = pixel_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= c.cmd;
          s_tdata  <= {c.count, c.color};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on each accepted command, check each result beat
  always @(posedge clk) begin : monitor
    pixel_result_t got, want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("windowed_pixel_cursor verification failed");
      $finish;
    end else begin
      in_fire = !rst && s_tvalid && s_tready;
      if (in_fire)
        expected_pixels.push_back(step_cursor(cmd_kind_t'(s_tuser), s_tdata[15:0],
                                              s_tdata[31:16]));
      if (!rst && m_tvalid && m_tready) begin
        got.strobe   = m_tuser;
        got.addr     = m_tdata[31:0];
        got.color    = m_tdata[47:32];
        got.col      = m_tdata[55:48];
        got.row      = m_tdata[64:56];
        got.width    = m_tdata[72:65];
        got.height   = m_tdata[81:73];
        got.row_skip = m_tdata[89:82];
        if (expected_pixels.size() == 0) begin
          check_field("unexpected result beat", 32'd1, 32'd0);
        end else begin
          want = expected_pixels.pop_front();
          check_field("write_strobe", 32'(got.strobe), 32'(want.strobe));
          check_field("pixel_address", got.addr, want.addr);
          check_field("pixel_color", 32'(got.color), 32'(want.color));
          check_field("next_column", 32'(got.col), 32'(want.col));
          check_field("next_row", 32'(got.row), 32'(want.row));
          check_field("window_width", 32'(got.width), 32'(want.width));
          check_field("window_height", 32'(got.height), 32'(want.height));
          check_field("row_skip", 32'(got.row_skip), 32'(want.row_skip));
        end
      end
    end
  end

endmodule

`default_nettype wire
